/* rtl/lct_pkg.sv */
package lct_pkg;

    localparam int unsigned MAX_CUES_DEF = 64;
    localparam int unsigned TICK_W       = 16;
    localparam int unsigned PAT_W        = 16;
    localparam int unsigned CFG_DATA_W   = 16;

    // Command codes.
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Outcome codes.
    localparam logic [1:0] OUT_DONE  = 2'd0;
    localparam logic [1:0] OUT_RANGE = 2'd1;
    localparam logic [1:0] OUT_FULL  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_LIGHTS_ENABLED = 1'b0;
    localparam logic REG_LENGTH_TICKS   = 1'b1;

    // One table entry as stored in the cue memory.
    typedef struct packed {
        logic              vld;
        logic [TICK_W-1:0] cue_tick;
        logic [PAT_W-1:0]  cue_pat;
    } lct_entry_t;

    localparam int unsigned ENTRY_W = $bits(lct_entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic wipe;
        logic commit;
    } lct_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quick;
    } lct_sts_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CLEAR  = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_COMMIT = 6'b100000
    } lct_state_t;

endpackage

/* rtl/lct_ram.sv */
module lct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/lct_datapath.sv */
module lct_datapath #(
    parameter int unsigned MAX_CUES = lct_pkg::MAX_CUES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lct_pkg::lct_ctl_t                   ctl,
    input  logic [$clog2(MAX_CUES)-1:0]         addr,
    output lct_pkg::lct_sts_t                   sts,
    input  logic                                cfg_valid,
    input  logic                                cfg_index,
    input  logic [lct_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [1:0]                          command,
    input  logic [lct_pkg::TICK_W-1:0]          tick,
    input  logic [lct_pkg::PAT_W-1:0]           pattern_in,
    output logic [lct_pkg::PAT_W-1:0]           pattern_out,
    output logic [1:0]                          outcome
);

    import lct_pkg::*;

    localparam int unsigned AW = $clog2(MAX_CUES);

    logic              lights_en_reg;
    logic [TICK_W-1:0] length_reg;

    logic [1:0]        cmd_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [PAT_W-1:0]  pat_reg;

    logic              vld_reg;
    logic [AW-1:0]     idx_reg;

    logic              match_found_reg, match_found_next;
    logic [AW-1:0]     match_idx_reg, match_idx_next;
    logic              free_found_reg, free_found_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;
    logic              best_found_reg, best_found_next;
    logic [TICK_W-1:0] best_tick_reg, best_tick_next;
    logic [PAT_W-1:0]  best_pat_reg, best_pat_next;

    logic [PAT_W-1:0]  pattern_out_reg, pattern_out_next;
    logic [1:0]        outcome_reg, outcome_next;

    logic              we;
    logic [AW-1:0]     waddr;
    lct_entry_t        wdata;
    lct_entry_t        rdata;
    logic              out_of_range;

    lct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CUES)
    ) u_cue_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctl.rd_en),
        .raddr (addr),
        .rdata (rdata)
    );

    assign out_of_range = (tick_reg >= length_reg);

    // Items that need no pass over the table finish straight away.
    assign sts.quick = ((cmd_reg == CMD_ADD) && out_of_range)
                    || ((cmd_reg == CMD_QUERY) && (out_of_range || !lights_en_reg))
                    || ((cmd_reg != CMD_ADD) && (cmd_reg != CMD_REMOVE)
                        && (cmd_reg != CMD_QUERY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lights_en_reg <= 1'b0;
            length_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LIGHTS_ENABLED: lights_en_reg <= cfg_data[0];
                REG_LENGTH_TICKS:   length_reg    <= cfg_data[TICK_W-1:0];
                default:            lights_en_reg <= lights_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            tick_reg <= tick;
            pat_reg  <= pattern_in;
        end
        idx_reg <= addr;
    end

    // Fold one entry per cycle into the search results.
    always_comb
    begin
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        best_found_next  = best_found_reg;
        best_tick_next   = best_tick_reg;
        best_pat_next    = best_pat_reg;
        if (ctl.load)
        begin
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
            best_found_next  = 1'b0;
            best_tick_next   = '0;
            best_pat_next    = '0;
        end
        else if (vld_reg)
        begin
            if (rdata.vld && (rdata.cue_tick == tick_reg) && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = idx_reg;
            end
            if (!rdata.vld && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = idx_reg;
            end
            if (rdata.vld && (rdata.cue_tick <= tick_reg)
                && (!best_found_reg || (rdata.cue_tick > best_tick_reg)))
            begin
                best_found_next = 1'b1;
                best_tick_next  = rdata.cue_tick;
                best_pat_next   = rdata.cue_pat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else
        begin
            vld_reg         <= ctl.rd_en;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            best_found_reg  <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        best_tick_reg <= best_tick_next;
        best_pat_reg  <= best_pat_next;
    end

    always_comb
    begin
        we               = 1'b0;
        waddr            = addr;
        wdata            = '0;
        pattern_out_next = '0;
        outcome_next     = OUT_DONE;
        if (ctl.wipe)
        begin
            we = 1'b1;
        end
        else if (ctl.commit)
        begin
            case (cmd_reg)
                CMD_ADD:
                begin
                    if (out_of_range)
                    begin
                        outcome_next = OUT_RANGE;
                    end
                    else if (match_found_reg || free_found_reg)
                    begin
                        we             = 1'b1;
                        waddr          = match_found_reg ? match_idx_reg : free_idx_reg;
                        wdata.vld      = 1'b1;
                        wdata.cue_tick = tick_reg;
                        wdata.cue_pat  = pat_reg;
                    end
                    else
                    begin
                        outcome_next = OUT_FULL;
                    end
                end
                CMD_REMOVE:
                begin
                    if (match_found_reg)
                    begin
                        we    = 1'b1;
                        waddr = match_idx_reg;
                    end
                end
                CMD_QUERY:
                begin
                    if (out_of_range)
                    begin
                        outcome_next = OUT_RANGE;
                    end
                    else if (lights_en_reg)
                    begin
                        pattern_out_next = best_pat_reg;
                    end
                end
                default:
                begin
                    outcome_next = OUT_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            pattern_out_reg <= pattern_out_next;
            outcome_reg     <= outcome_next;
        end
    end

    assign pattern_out = pattern_out_reg;
    assign outcome     = outcome_reg;

endmodule

/* rtl/lct_ctrl.sv */
module lct_ctrl #(
    parameter int unsigned MAX_CUES = lct_pkg::MAX_CUES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    output lct_pkg::lct_ctl_t           ctl,
    output logic [$clog2(MAX_CUES)-1:0] addr,
    input  lct_pkg::lct_sts_t           sts
);

    import lct_pkg::*;

    localparam int unsigned AW = $clog2(MAX_CUES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CUES - 1);

    lct_state_t    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        done_next  = 1'b0;
        ctl        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.wipe = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                addr_next  = '0;
                state_next = sts.quick ? ST_COMMIT : ST_SCAN;
            end
            ST_SCAN:
            begin
                ctl.rd_en = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // The read of the last entry lands in this cycle.
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                ctl.commit = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign addr = addr_reg;

endmodule

/* rtl/light_cue_timeline.sv */
// Channel    Handshake            Payload
// command    start / busy         command, tick, pattern_in
// result     done (one cycle)     pattern_out, outcome
// config     cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An in-range add, a remove or an in-range enabled query reads every table entry
// once through the single read port of the cue memory. Other items skip the pass
// over the table. After reset the memory is cleared one entry per cycle with busy
// high; configuration writes are taken at all times.
// Results cannot be held off, and a new item is taken in the cycle done is high.
module light_cue_timeline #(
    parameter int unsigned MAX_CUES = lct_pkg::MAX_CUES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     command,
    input  logic [lct_pkg::TICK_W-1:0]     tick,
    input  logic [lct_pkg::PAT_W-1:0]      pattern_in,
    output logic                           done,
    output logic [lct_pkg::PAT_W-1:0]      pattern_out,
    output logic [1:0]                     outcome,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [lct_pkg::CFG_DATA_W-1:0] cfg_data
);

    import lct_pkg::*;

    lct_ctl_t                    ctl;
    lct_sts_t                    sts;
    logic [$clog2(MAX_CUES)-1:0] addr;

    assign cfg_ready = 1'b1;

    lct_ctrl #(
        .MAX_CUES (MAX_CUES)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl),
        .addr  (addr),
        .sts   (sts)
    );

    lct_datapath #(
        .MAX_CUES (MAX_CUES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .addr        (addr),
        .sts         (sts),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .command     (command),
        .tick        (tick),
        .pattern_in  (pattern_in),
        .pattern_out (pattern_out),
        .outcome     (outcome)
    );

endmodule
